// ----- hdl/srhc_pkg.sv -----
package srhc_pkg;

    // Tick throttle and Q1.14 scaling
    localparam int unsigned MIN_INTERVAL_MS = 100;
    localparam int unsigned FRACTION_BITS   = 14;

    localparam int unsigned LEVEL_W = FRACTION_BITS + 1;  // 0 .. 1.0 inclusive
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned PID_W   = 16;

    // Configuration port
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // Register select: bit 2 of the byte address picks the register
    typedef enum logic
    {
        REG_DEADBAND   = 1'b0,
        REG_CHANGEOVER = 1'b1
    } reg_sel_t;

    // One input tick, packed with now_ms in the lowest bits
    typedef struct packed
    {
        logic [4:0]               pad;
        logic                     tuning;
        logic                     sensor_valid;
        logic                     enabled;
        logic signed [PID_W-1:0]  pid_out;
        logic [TIME_W-1:0]        now_ms;
    } tick_t;

    localparam int unsigned TICK_W = $bits(tick_t);

    // One result, packed with heat_cmd in the lowest bits
    typedef struct packed
    {
        logic                 cool_active;
        logic                 heat_active;
        logic [LEVEL_W-1:0]   cool_cmd;
        logic [LEVEL_W-1:0]   heat_cmd;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

    // Drive state carried from tick to tick
    typedef struct packed
    {
        logic                 has_started;
        logic [TIME_W-1:0]    last_tick_time;
        logic                 heat_is_on;
        logic                 cool_is_on;
        logic [TIME_W-1:0]    heat_off_time;
        logic [TIME_W-1:0]    cool_off_time;
        logic                 heat_off_known;
        logic                 cool_off_known;
    } drive_state_t;

    // Settings from the register file
    typedef struct packed
    {
        logic [LEVEL_W-1:0]   deadband;
        logic [TIME_W-1:0]    changeover_ms;
    } srhc_cfg_t;

endpackage

// ----- hdl/srhc_cfg.sv -----
module srhc_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srhc_pkg::APB_AW-1:0] paddr,
    input  logic [srhc_pkg::APB_DW-1:0] pwdata,
    output logic [srhc_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output srhc_pkg::srhc_cfg_t         cfg
);
    import srhc_pkg::*;

    logic [LEVEL_W-1:0] deadband_reg;
    logic [TIME_W-1:0]  changeover_reg;
    logic               wr_en;
    reg_sel_t           sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = reg_sel_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg   <= '0;
            changeover_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_DEADBAND:   deadband_reg   <= pwdata[LEVEL_W-1:0];
                REG_CHANGEOVER: changeover_reg <= pwdata[TIME_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_DEADBAND:   prdata = {{(APB_DW-LEVEL_W){1'b0}}, deadband_reg};
            REG_CHANGEOVER: prdata = changeover_reg;
            default:        prdata = '0;
        endcase
    end

    assign cfg.deadband      = deadband_reg;
    assign cfg.changeover_ms = changeover_reg;

endmodule

// ----- hdl/srhc_decide.sv -----
module srhc_decide
(
    input  srhc_pkg::tick_t        tick,
    input  srhc_pkg::drive_state_t st,
    input  srhc_pkg::srhc_cfg_t    cfg,
    output srhc_pkg::drive_state_t st_next,
    output srhc_pkg::result_t      res,
    output logic                   emit
);
    import srhc_pkg::*;

    localparam logic signed [PID_W:0] ONE_Q = (PID_W+1)'(1 << FRACTION_BITS);

    logic signed [PID_W:0] pid_x;
    logic signed [PID_W:0] pid_neg;
    logic signed [PID_W:0] db_x;
    logic [TIME_W-1:0]     since_tick;
    logic [TIME_W-1:0]     since_cool_off;
    logic [TIME_W-1:0]     since_heat_off;
    logic                  throttled;
    logic                  want_heat;
    logic                  want_cool;
    logic                  dead_active;
    logic [LEVEL_W-1:0]    heat_lvl;
    logic [LEVEL_W-1:0]    cool_lvl;

    assign pid_x   = {tick.pid_out[PID_W-1], tick.pid_out};
    assign pid_neg = -pid_x;
    assign db_x    = signed'({{(PID_W+1-LEVEL_W){1'b0}}, cfg.deadband});

    assign since_tick     = tick.now_ms - st.last_tick_time;
    assign since_cool_off = tick.now_ms - st.cool_off_time;
    assign since_heat_off = tick.now_ms - st.heat_off_time;
    assign throttled      = st.has_started && (since_tick < TIME_W'(MIN_INTERVAL_MS));
    assign dead_active    = (cfg.changeover_ms != '0) && !tick.tuning;

    assign heat_lvl = (pid_x > ONE_Q)   ? ONE_Q[LEVEL_W-1:0] : pid_x[LEVEL_W-1:0];
    assign cool_lvl = (pid_neg > ONE_Q) ? ONE_Q[LEVEL_W-1:0] : pid_neg[LEVEL_W-1:0];

    always_comb
    begin
        st_next   = st;
        res       = '0;
        emit      = 1'b0;
        want_heat = 1'b0;
        want_cool = 1'b0;

        if (!tick.enabled || !tick.sensor_valid)
        begin
            // forced off: record switch-off times, report all zeros
            if (st.heat_is_on)
            begin
                st_next.heat_is_on     = 1'b0;
                st_next.heat_off_time  = tick.now_ms;
                st_next.heat_off_known = 1'b1;
            end
            if (st.cool_is_on)
            begin
                st_next.cool_is_on     = 1'b0;
                st_next.cool_off_time  = tick.now_ms;
                st_next.cool_off_known = 1'b1;
            end
            emit = 1'b1;
        end
        else if (!throttled)
        begin
            st_next.has_started    = 1'b1;
            st_next.last_tick_time = tick.now_ms;

            want_heat = pid_x > db_x;
            want_cool = pid_neg > db_x;

            if (dead_active)
            begin
                if (want_heat && !st.heat_is_on &&
                    (st.cool_is_on ||
                     (st.cool_off_known && since_cool_off < cfg.changeover_ms)))
                    want_heat = 1'b0;
                if (want_cool && !st.cool_is_on &&
                    (st.heat_is_on ||
                     (st.heat_off_known && since_heat_off < cfg.changeover_ms)))
                    want_cool = 1'b0;
            end

            // interlock: never both
            if (want_heat && want_cool)
            begin
                want_heat = 1'b0;
                want_cool = 1'b0;
            end

            st_next.heat_is_on = want_heat;
            st_next.cool_is_on = want_cool;
            if (st.heat_is_on && !want_heat)
            begin
                st_next.heat_off_time  = tick.now_ms;
                st_next.heat_off_known = 1'b1;
            end
            if (st.cool_is_on && !want_cool)
            begin
                st_next.cool_off_time  = tick.now_ms;
                st_next.cool_off_known = 1'b1;
            end

            res.heat_cmd    = want_heat ? heat_lvl : '0;
            res.cool_cmd    = want_cool ? cool_lvl : '0;
            res.heat_active = want_heat;
            res.cool_active = want_cool;
            emit = 1'b1;
        end
    end

endmodule

// ----- hdl/split_range_heat_cool_output_stage.sv -----
// Split-range heat/cool output stage. Each transfer on the s_ side is one
// control tick (timestamp, signed Q1.14 controller output, enable, sensor
// valid, tuning); the block answers with at most one transfer on the m_ side
// carrying the heat and cool drive levels and which side is on. Enabled ticks
// with a valid sensor that arrive less than 100 ms after the last accepted
// tick produce no result; a disabled tick or one with an invalid sensor
// always produces an all-zero result.
// Timing: a tick is taken into an input register, decided by one pass of
// compare/clamp logic and a 32-bit elapsed-time subtract against the drive
// state, and lands in the result register, which drives m_tvalid. Throughput
// is one tick per cycle, set by the drive state update that each tick needs
// from the one before it; the input stalls only while a result waits in the
// result register with m_tready low. Registers (APB, byte addresses): 0x0
// deadband (15 bits), 0x4 changeover_ms (32 bits, 0 turns the dead time
// off). Write them only while no tick is in flight.
module split_range_heat_cool_output_stage
(
    input  logic                          clk,
    input  logic                          rst_n,

    // tick in: [31:0] now_ms, [47:32] pid_out, [48] enabled,
    //          [49] sensor_valid, [50] tuning, [55:51] zero
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [srhc_pkg::TICK_W-1:0]   s_tdata,

    // result out: [14:0] heat_cmd, [29:15] cool_cmd, [30] heat_active,
    //             [31] cool_active
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [srhc_pkg::RESULT_W-1:0] m_tdata,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srhc_pkg::APB_AW-1:0]   paddr,
    input  logic [srhc_pkg::APB_DW-1:0]   pwdata,
    output logic [srhc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import srhc_pkg::*;

    srhc_cfg_t    cfg;
    tick_t        tick_reg;
    logic         tick_valid_reg;
    drive_state_t state_reg;
    drive_state_t state_next;
    result_t      res_next;
    result_t      res_reg;
    logic         res_valid_reg;
    logic         emit;
    logic         advance;

    srhc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srhc_decide u_decide
    (
        .tick    (tick_reg),
        .st      (state_reg),
        .cfg     (cfg),
        .st_next (state_next),
        .res     (res_next),
        .emit    (emit)
    );

    // Advance the held tick whenever the result register is free or being
    // drained this cycle; the input register then refills in the same cycle.
    assign advance  = tick_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !tick_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (s_tready)
                tick_valid_reg <= s_tvalid;

            // Commit the drive state once per tick, even for a dropped tick
            // (where it is left unchanged by the decision logic).
            if (advance)
                state_reg <= state_next;

            if (advance)
                res_valid_reg <= emit;
            else if (m_tready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            tick_reg <= tick_t'(s_tdata);
        if (advance && emit)
            res_reg <= res_next;
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = res_reg;

endmodule
